>>> sv/msr_pkg.sv
package msr_pkg;

	// Default modulus width in bits
	localparam int MSR_MOD_BITS = 31;

	// Upper bound on the non-residue search
	localparam int NR_SEARCH_LIMIT = 4096;

	// Operation requested from the exponentiation unit
	typedef enum logic {
		OP_MUL = 1'b0,
		OP_POW = 1'b1
	} pow_op_t;

endpackage

>>> sv/modular_square_root.sv
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, value                | to block
// out     | out_valid, out_ready, root, no_root      | from block
// cfg     | cfg_valid, cfg_ready, prime_modulus      | to block
//
// One transaction at a time; each modular multiply runs in the bit-serial
// multiplier, and each exponentiation takes up to 2*MOD_BITS multiplies.
// Primes 1 mod 4 take longer per value (non-residue search and
// Tonelli-Shanks loop).
// Asynchronous reset sets the modulus to 3. A stalled result holds in the
// output register; in_ready stays low until it is taken.
module modular_square_root import msr_pkg::*; #(
	parameter int MOD_BITS = MSR_MOD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MOD_BITS-1:0] value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MOD_BITS-1:0] root,
	output logic                no_root,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [MOD_BITS-1:0] prime_modulus
);

	localparam int SW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

	typedef enum logic [15:0] {
		T_IDLE = 16'h0001,
		T_RED  = 16'h0002,
		T_EUL  = 16'h0004,
		T_R34  = 16'h0008,
		T_QS   = 16'h0010,
		T_Z    = 16'h0020,
		T_C    = 16'h0040,
		T_R    = 16'h0080,
		T_T    = 16'h0100,
		T_LOOP = 16'h0200,
		T_I    = 16'h0400,
		T_B    = 16'h0800,
		T_CS   = 16'h1000,
		T_TM   = 16'h2000,
		T_RM   = 16'h4000,
		T_OUT  = 16'h8000
	} tstate_t;

	tstate_t             state_q;
	logic [MOD_BITS-1:0] p_q;
	logic [MOD_BITS-1:0] n_q;
	logic [MOD_BITS-1:0] q_q;
	logic [MOD_BITS-1:0] z_q;
	logic [MOD_BITS-1:0] c_q;
	logic [MOD_BITS-1:0] r_q;
	logic [MOD_BITS-1:0] t_q;
	logic [MOD_BITS-1:0] b_q;
	logic [SW-1:0]       s_q;
	logic [SW-1:0]       m_q;
	logic [SW-1:0]       i_q;
	logic [SW-1:0]       k_q;
	logic [MOD_BITS-1:0] root_q;
	logic                no_root_q;

	logic                pstart_q;
	pow_op_t             pop_q;
	logic [MOD_BITS-1:0] px_q;
	logic [MOD_BITS-1:0] py_q;
	logic                p_done;
	logic [MOD_BITS-1:0] p_res;

	logic [MOD_BITS-1:0] half_pm1;
	logic [MOD_BITS-1:0] quarter_pp1;
	logic [MOD_BITS-1:0] half_qp1;
	logic [MOD_BITS-1:0] z_next;
	logic                res_one;
	logic [SW-1:0]       k_init;

	assign half_pm1    = (p_q - MOD_BITS'(1)) >> 1;
	assign quarter_pp1 = (p_q >> 2) + MOD_BITS'(1);
	assign half_qp1    = (q_q >> 1) + MOD_BITS'(1);
	assign z_next      = z_q + MOD_BITS'(1);
	assign res_one     = (p_res == MOD_BITS'(1));
	assign k_init      = m_q - i_q - SW'(1);

	msr_powmod #(.MOD_BITS(MOD_BITS)) u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pstart_q),
		.op     (pop_q),
		.x      (px_q),
		.y      (py_q),
		.m      (p_q),
		.done   (p_done),
		.res    (p_res)
	);

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			p_q <= MOD_BITS'(3);
		else if (cfg_valid && cfg_ready)
			p_q <= prime_modulus;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			pstart_q  <= 1'b0;
			pop_q     <= OP_MUL;
			px_q      <= '0;
			py_q      <= '0;
			n_q       <= '0;
			q_q       <= '0;
			z_q       <= '0;
			c_q       <= '0;
			r_q       <= '0;
			t_q       <= '0;
			b_q       <= '0;
			s_q       <= '0;
			m_q       <= '0;
			i_q       <= '0;
			k_q       <= '0;
			root_q    <= '0;
			no_root_q <= 1'b0;
		end else begin
			pstart_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_valid) begin
						if (p_q < MOD_BITS'(2)) begin
							root_q    <= '0;
							no_root_q <= 1'b0;
							state_q   <= T_OUT;
						end else if (p_q == MOD_BITS'(2)) begin
							root_q    <= {{(MOD_BITS-1){1'b0}}, value[0]};
							no_root_q <= 1'b0;
							state_q   <= T_OUT;
						end else begin
							pop_q    <= OP_MUL;
							px_q     <= MOD_BITS'(1);
							py_q     <= value;
							pstart_q <= 1'b1;
							state_q  <= T_RED;
						end
					end
				end
				T_RED: begin
					if (p_done) begin
						n_q <= p_res;
						if (p_res == '0) begin
							root_q    <= '0;
							no_root_q <= 1'b0;
							state_q   <= T_OUT;
						end else begin
							pop_q    <= OP_POW;
							px_q     <= p_res;
							py_q     <= half_pm1;
							pstart_q <= 1'b1;
							state_q  <= T_EUL;
						end
					end
				end
				T_EUL: begin
					if (p_done) begin
						if (!res_one) begin
							root_q    <= '0;
							no_root_q <= 1'b1;
							state_q   <= T_OUT;
						end else if (p_q[1:0] == 2'b11) begin
							pop_q    <= OP_POW;
							px_q     <= n_q;
							py_q     <= quarter_pp1;
							pstart_q <= 1'b1;
							state_q  <= T_R34;
						end else begin
							q_q     <= p_q - MOD_BITS'(1);
							s_q     <= '0;
							state_q <= T_QS;
						end
					end
				end
				T_R34: begin
					if (p_done) begin
						root_q    <= p_res;
						no_root_q <= 1'b0;
						state_q   <= T_OUT;
					end
				end
				T_QS: begin
					// strip factors of two from p-1
					if (q_q != '0 && !q_q[0]) begin
						q_q <= q_q >> 1;
						s_q <= s_q + SW'(1);
					end else begin
						z_q      <= MOD_BITS'(2);
						pop_q    <= OP_POW;
						px_q     <= MOD_BITS'(2);
						py_q     <= half_pm1;
						pstart_q <= 1'b1;
						state_q  <= T_Z;
					end
				end
				T_Z: begin
					if (p_done) begin
						if (!res_one) begin
							pop_q    <= OP_POW;
							px_q     <= z_q;
							py_q     <= q_q;
							pstart_q <= 1'b1;
							state_q  <= T_C;
						end else if (z_next >= p_q ||
								64'(z_next) >= 64'(NR_SEARCH_LIMIT)) begin
							root_q    <= '0;
							no_root_q <= 1'b1;
							state_q   <= T_OUT;
						end else begin
							z_q      <= z_next;
							pop_q    <= OP_POW;
							px_q     <= z_next;
							py_q     <= half_pm1;
							pstart_q <= 1'b1;
						end
					end
				end
				T_C: begin
					if (p_done) begin
						c_q      <= p_res;
						pop_q    <= OP_POW;
						px_q     <= n_q;
						py_q     <= half_qp1;
						pstart_q <= 1'b1;
						state_q  <= T_R;
					end
				end
				T_R: begin
					if (p_done) begin
						r_q      <= p_res;
						pop_q    <= OP_POW;
						px_q     <= n_q;
						py_q     <= q_q;
						pstart_q <= 1'b1;
						state_q  <= T_T;
					end
				end
				T_T: begin
					if (p_done) begin
						t_q     <= p_res;
						m_q     <= s_q;
						state_q <= T_LOOP;
					end
				end
				T_LOOP: begin
					if (t_q == MOD_BITS'(1)) begin
						root_q    <= r_q;
						no_root_q <= 1'b0;
						state_q   <= T_OUT;
					end else begin
						i_q      <= SW'(1);
						pop_q    <= OP_MUL;
						px_q     <= t_q;
						py_q     <= t_q;
						pstart_q <= 1'b1;
						state_q  <= T_I;
					end
				end
				T_I: begin
					// find the least i with t^(2^i) == 1
					if (p_done) begin
						if (!res_one && i_q < m_q) begin
							i_q      <= i_q + SW'(1);
							pop_q    <= OP_MUL;
							px_q     <= p_res;
							py_q     <= p_res;
							pstart_q <= 1'b1;
						end else if (i_q >= m_q) begin
							root_q    <= '0;
							no_root_q <= 1'b1;
							state_q   <= T_OUT;
						end else begin
							b_q      <= c_q;
							k_q      <= k_init;
							pop_q    <= OP_MUL;
							px_q     <= c_q;
							py_q     <= c_q;
							pstart_q <= 1'b1;
							state_q  <= (k_init == '0) ? T_CS : T_B;
						end
					end
				end
				T_B: begin
					if (p_done) begin
						b_q      <= p_res;
						k_q      <= k_q - SW'(1);
						pop_q    <= OP_MUL;
						px_q     <= p_res;
						py_q     <= p_res;
						pstart_q <= 1'b1;
						if (k_q == SW'(1))
							state_q <= T_CS;
					end
				end
				T_CS: begin
					if (p_done) begin
						c_q      <= p_res;
						pop_q    <= OP_MUL;
						px_q     <= t_q;
						py_q     <= p_res;
						pstart_q <= 1'b1;
						state_q  <= T_TM;
					end
				end
				T_TM: begin
					if (p_done) begin
						t_q      <= p_res;
						pop_q    <= OP_MUL;
						px_q     <= r_q;
						py_q     <= b_q;
						pstart_q <= 1'b1;
						state_q  <= T_RM;
					end
				end
				T_RM: begin
					if (p_done) begin
						r_q     <= p_res;
						m_q     <= i_q;
						state_q <= T_LOOP;
					end
				end
				T_OUT: begin
					if (out_ready)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == T_IDLE);
	assign out_valid = (state_q == T_OUT);
	assign root      = root_q;
	assign no_root   = no_root_q;
	assign cfg_ready = 1'b1;

endmodule

>>> sv/msr_mulmod.sv
// Bit-serial modular multiplier: one bit of y per cycle, MSB first.
module msr_mulmod import msr_pkg::*; #(
	parameter int MOD_BITS = MSR_MOD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] x,
	input  logic [MOD_BITS-1:0] y,
	input  logic [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] res
);

	localparam int CW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] x_q;
	logic [MOD_BITS-1:0] y_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;

	// Double the accumulator, then add x when the current bit is set
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum     = dbl_red + (y_q[MOD_BITS-1] ? {1'b0, x_q} : '0);
		sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MOD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= sum_red[MOD_BITS-1:0];
			y_q   <= {y_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

>>> sv/msr_powmod.sv
// Modular exponentiation by square and multiply, exponent MSB first.
// Also performs a single modular multiply.
module msr_powmod import msr_pkg::*; #(
	parameter int MOD_BITS = MSR_MOD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pow_op_t             op,
	input  logic [MOD_BITS-1:0] x,
	input  logic [MOD_BITS-1:0] y,
	input  logic [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] res
);

	localparam int CW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

	typedef enum logic [2:0] {
		P_IDLE = 3'b001,
		P_SQ   = 3'b010,
		P_ML   = 3'b100
	} pstate_t;

	pstate_t             state_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] base_q;
	logic [MOD_BITS-1:0] e_q;
	logic [CW-1:0]       cnt_q;
	logic                single_q;
	logic                mstart_q;
	logic                done_q;

	logic                m_done;
	logic [MOD_BITS-1:0] m_res;
	logic [MOD_BITS-1:0] m_y;

	assign m_y = (state_q == P_SQ) ? acc_q : base_q;

	msr_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.x      (acc_q),
		.y      (m_y),
		.m      (m),
		.done   (m_done),
		.res    (m_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= P_IDLE;
			mstart_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			single_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						cnt_q    <= '0;
						single_q <= (op == OP_MUL);
						mstart_q <= 1'b1;
						state_q  <= (op == OP_MUL) ? P_ML : P_SQ;
					end
				end
				P_SQ: begin
					if (m_done) begin
						if (e_q[MOD_BITS-1]) begin
							mstart_q <= 1'b1;
							state_q  <= P_ML;
						end else if (cnt_q == CW'(MOD_BITS - 1)) begin
							done_q  <= 1'b1;
							state_q <= P_IDLE;
						end else begin
							cnt_q    <= cnt_q + CW'(1);
							mstart_q <= 1'b1;
						end
					end
				end
				P_ML: begin
					if (m_done) begin
						if (single_q || cnt_q == CW'(MOD_BITS - 1)) begin
							done_q  <= 1'b1;
							state_q <= P_IDLE;
						end else begin
							cnt_q    <= cnt_q + CW'(1);
							mstart_q <= 1'b1;
							state_q  <= P_SQ;
						end
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	// Accumulator, base and exponent shift register
	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start) begin
			acc_q  <= (op == OP_MUL) ? x : MOD_BITS'(1);
			base_q <= (op == OP_MUL) ? y : x;
			e_q    <= y;
		end else if (m_done) begin
			acc_q <= m_res;
			if ((state_q == P_SQ && !e_q[MOD_BITS-1]) || state_q == P_ML)
				e_q <= {e_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

>>> sv/msr_checker.sv
module msr_checker import msr_pkg::*; #(
	parameter int MOD_BITS = MSR_MOD_BITS
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [MOD_BITS-1:0] value,
	input logic                out_valid,
	input logic                out_ready,
	input logic [MOD_BITS-1:0] root,
	input logic                no_root,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [MOD_BITS-1:0] prime_modulus
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root) && $stable(no_root))
		else $error("stalled result changed");

	// No root reports root zero
	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_root |-> root == '0)
		else $error("no_root with nonzero root");

	// Drop ready after an input transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// Never take input while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("ready with pending result");

endmodule

bind modular_square_root msr_checker #(.MOD_BITS(MOD_BITS)) u_msr_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import msr_pkg::*;

	localparam int  W         = MSR_MOD_BITS;
	localparam int  CYC_LIMIT = 8000000;
	localparam int  SETTLE    = 200;

	typedef logic [W-1:0] word_t;

	typedef struct {
		word_t root;
		logic  no_root;
	} sqrt_res_t;

	// Predict roots for the current modulus and hold them until they come out
	class sqrt_scoreboard;
		longint unsigned modulus;
		sqrt_res_t       pending_roots[$];
		int              errors;

		function new();
			modulus = 3;
			errors  = 0;
		endfunction

		function longint unsigned mulmod(longint unsigned x, longint unsigned y,
				longint unsigned m);
			return (x * y) % m;
		endfunction

		function longint unsigned powmod(longint unsigned b, longint unsigned e,
				longint unsigned m);
			longint unsigned acc;
			acc = 1 % m;
			b   = b % m;
			while (e != 0) begin
				if (e[0])
					acc = mulmod(acc, b, m);
				b = mulmod(b, b, m);
				e = e >> 1;
			end
			return acc;
		endfunction

		function bit is_residue(longint unsigned x, longint unsigned m);
			return powmod(x, (m - 1) / 2, m) == 1;
		endfunction

		function sqrt_res_t compute_root(longint unsigned n);
			sqrt_res_t       res;
			longint unsigned p, q, s, z, c, r, t, mm, i, tmp, b;
			p           = modulus;
			res.root    = '0;
			res.no_root = 1'b0;
			if (p < 2)
				return res;
			n = n % p;
			if (p == 2) begin
				res.root = word_t'(n);
				return res;
			end
			if (n == 0)
				return res;
			res.no_root = 1'b1;
			if (!is_residue(n, p))
				return res;
			if ((p & 3) == 3) begin
				res.no_root = 1'b0;
				res.root    = word_t'(powmod(n, (p + 1) / 4, p));
				return res;
			end
			// split p-1 into q * 2^s
			q = p - 1;
			s = 0;
			while (q != 0 && q[0] == 1'b0) begin
				q = q >> 1;
				s++;
			end
			// search the smallest non-residue
			z = 2;
			while (is_residue(z, p)) begin
				z++;
				if (z >= p || z >= NR_SEARCH_LIMIT)
					return res;
			end
			c  = powmod(z, q, p);
			r  = powmod(n, (q + 1) / 2, p);
			t  = powmod(n, q, p);
			mm = s;
			while (t != 1) begin
				i   = 1;
				tmp = mulmod(t, t, p);
				while (tmp != 1 && i < mm) begin
					tmp = mulmod(tmp, tmp, p);
					i++;
				end
				if (i >= mm)
					return res;
				b = c;
				for (longint unsigned k = 0; k + i + 1 < mm; k++)
					b = mulmod(b, b, p);
				c  = mulmod(b, b, p);
				t  = mulmod(t, c, p);
				r  = mulmod(r, b, p);
				mm = i;
			end
			res.no_root = 1'b0;
			res.root    = word_t'(r);
			return res;
		endfunction

		function void note_value(word_t v);
			pending_roots.push_back(compute_root(v));
		endfunction

		function void check_root(word_t root, logic no_root);
			sqrt_res_t e;
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected result root=%0d no_root=%0b", $time,
					root, no_root);
				errors++;
				return;
			end
			e = pending_roots.pop_front();
			if (root !== e.root) begin
				$display("%0t: root mismatch expected %0d actual %0d", $time, e.root, root);
				errors++;
			end
			if (no_root !== e.no_root) begin
				$display("%0t: no_root mismatch expected %0b actual %0b", $time,
					e.no_root, no_root);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_roots.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	word_t value = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t root;
	logic  no_root;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	word_t prime_modulus = '0;

	sqrt_scoreboard sb = new();
	int  n_in      = 0;
	int  n_out     = 0;
	int  n_cfg     = 0;
	int  cycles    = 0;
	bit  quiet     = 1'b0;
	int  last_out  = 0;
	int  out_wait  = 0;

	modular_square_root uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.root          (root),
		.no_root       (no_root),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.prime_modulus (prime_modulus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Observe every transaction on the pre-edge values
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("** modular_square_root: FAILED **");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_value(value);
				n_in++;
			end
			if (out_valid && out_ready) begin
				sb.check_root(root, no_root);
				n_out++;
			end
			if (cfg_valid && cfg_ready) begin
				sb.modulus = prime_modulus;
				n_cfg++;
			end
		end
	end

	// Stall the result side for a random count after each transaction
	always @(negedge clk) begin
		if (n_out != last_out) begin
			last_out = n_out;
			out_wait = quiet ? 0 : $urandom_range(0, 16);
		end
		if (out_wait > 0) begin
			out_ready <= 1'b0;
			out_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_value(word_t v);
		int gap;
		int target;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		target = n_in + 1;
		in_valid <= 1'b1;
		value    <= v;
		while (n_in < target)
			@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_modulus(word_t p);
		int target;
		drain();
		target = n_cfg + 1;
		cfg_valid     <= 1'b1;
		prime_modulus <= p;
		while (n_cfg < target)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(word_t p, bit directed, int n_rand);
		word_t v;
		if (directed) begin
			send_value('0);
			send_value(word_t'(1));
			send_value(p - word_t'(1));
			send_value(p);
			send_value('1);
		end
		for (int k = 0; k < n_rand; k++) begin
			// hold off until all results are back once per phase
			if (k == 4)
				drain();
			if (p > 1 && $urandom_range(0, 1))
				v = word_t'($urandom_range(0, int'(p) - 1));
			else
				v = word_t'($urandom);
			send_value(v);
		end
	endtask

	initial begin
		word_t moduli[$];
		bit    dir_set[$];
		moduli  = '{word_t'(3), word_t'(2), word_t'(0), word_t'(1), word_t'(7),
			word_t'(13), word_t'(17), word_t'(41), word_t'(25), word_t'(15),
			word_t'(2147483647), word_t'(998244353), word_t'(2013265921), word_t'(3)};
		dir_set = '{1, 1, 1, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 0};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// first phase runs on the reset modulus
		foreach (moduli[i]) begin
			quiet = (i % 3 == 2);
			if (i != 0)
				write_modulus(moduli[i]);
			run_phase(moduli[i], dir_set[i], 5);
		end
		drain();

		if (sb.errors == 0)
			$display("** modular_square_root: PASSED **");
		else
			$display("** modular_square_root: FAILED **");
		$finish;
	end

endmodule

>>> files.f
sv/msr_pkg.sv
sv/msr_mulmod.sv
sv/msr_powmod.sv
sv/modular_square_root.sv
sv/msr_checker.sv
tb/tb_top.sv
